/* hw/rtl/u8sd_pkg.sv */
// Shared types, constants and byte classification for the UTF-8 stream decoder.
package u8sd_pkg;

    localparam int unsigned CpW    = 21;
    localparam int unsigned LenW   = 3;
    localparam int unsigned CountW = 3;
    localparam int unsigned MaxRes = 4;

    typedef enum logic [2:0] {
        K_CONT,
        K_ASCII,
        K_LEAD2,
        K_LEAD3,
        K_LEAD4,
        K_BAD
    } t_kind;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        logic [CpW-1:0]  codepoint;
        logic [LenW-1:0] seq_length;
        logic            invalid;
        logic            run_last;
        logic            string_last;
    } t_out_beat;

    // Held sequence: lead byte, continuation payloads and how much is held.
    typedef struct packed {
        logic [7:0] lead;
        logic [5:0] cont0;
        logic [5:0] cont1;
        logic [1:0] pcount;
    } t_dec_state;

    // Results caused by one byte: cnt results, all but the last one invalid.
    typedef struct packed {
        logic [CountW-1:0] cnt;
        logic [CpW-1:0]    cp;
        logic [LenW-1:0]   len;
        logic              inv;
        logic              str_last;
    } t_run;

    function automatic t_kind byte_kind(input logic [7:0] b);
        t_kind k;
        priority if (b[7] == 1'b0)       k = K_ASCII;
        else if (b[7:6] == 2'b10)        k = K_CONT;
        else if (b[7:5] == 3'b110)       k = K_LEAD2;
        else if (b[7:4] == 4'b1110)      k = K_LEAD3;
        else if (b[7:3] == 5'b11110)     k = K_LEAD4;
        else                             k = K_BAD;
        return k;
    endfunction

endpackage

/* hw/rtl/u8sd_decode.sv */
// Combinational decode of one byte against the held sequence.
module u8sd_decode (
    input  u8sd_pkg::t_dec_state i_state,
    input  u8sd_pkg::t_in_beat   i_beat,
    output u8sd_pkg::t_dec_state o_state,
    output u8sd_pkg::t_run       o_run
);

    always_comb begin
        u8sd_pkg::t_kind         kind;
        u8sd_pkg::t_kind         lead_kind;
        logic [1:0]              need;
        logic [1:0]              have;
        logic [5:0]              c;
        logic [7:0]              b;
        logic                    last;
        logic                    f_hold;
        logic [u8sd_pkg::CountW-1:0] f_cnt;
        logic [u8sd_pkg::CpW-1:0]    f_cp;
        logic                    f_inv;

        b         = i_beat.byte_in;
        last      = i_beat.last_byte;
        c         = b[5:0];
        kind      = u8sd_pkg::byte_kind(b);
        lead_kind = u8sd_pkg::byte_kind(i_state.lead);
        have      = i_state.pcount - 2'd1;

        unique case (lead_kind)
            u8sd_pkg::K_LEAD3: need = 2'd2;
            u8sd_pkg::K_LEAD4: need = 2'd3;
            default:           need = 2'd1;
        endcase

        // Handling of the byte as if nothing were held.
        f_hold = 1'b0;
        f_cnt  = u8sd_pkg::CountW'(1);
        f_cp   = '0;
        f_inv  = 1'b1;
        unique case (kind)
            u8sd_pkg::K_ASCII: begin
                f_cp  = u8sd_pkg::CpW'(b);
                f_inv = 1'b0;
            end
            u8sd_pkg::K_LEAD2, u8sd_pkg::K_LEAD3, u8sd_pkg::K_LEAD4: begin
                if (!last) begin
                    f_hold = 1'b1;
                    f_cnt  = '0;
                end
            end
            default: begin
            end
        endcase

        o_state      = i_state;
        o_run.cp     = '0;
        o_run.len    = u8sd_pkg::LenW'(1);
        o_run.inv    = 1'b1;
        o_run.cnt    = '0;
        o_run.str_last = last;

        if (i_state.pcount != 2'd0 && kind == u8sd_pkg::K_CONT) begin
            if ({1'b0, have} + 3'd1 >= {1'b0, need}) begin
                o_run.cnt = u8sd_pkg::CountW'(1);
                o_run.inv = 1'b0;
                o_run.len = u8sd_pkg::LenW'(need) + u8sd_pkg::LenW'(1);
                unique case (need)
                    2'd1: o_run.cp = {10'd0, i_state.lead[4:0], c};
                    2'd2: o_run.cp = {5'd0, i_state.lead[3:0], i_state.cont0, c};
                    default: o_run.cp = {i_state.lead[2:0], i_state.cont0,
                                         i_state.cont1, c};
                endcase
                o_state.pcount = 2'd0;
            end else begin
                if (have[0]) o_state.cont1 = c;
                else         o_state.cont0 = c;
                o_state.pcount = i_state.pcount + 2'd1;
                // The string ends inside the sequence: every held byte and
                // this one come out as invalid.
                if (last) begin
                    o_run.cnt = u8sd_pkg::CountW'(i_state.pcount) +
                                u8sd_pkg::CountW'(1);
                end
            end
        end else begin
            // Flush whatever is held, then take the byte afresh.
            o_run.cnt = u8sd_pkg::CountW'(i_state.pcount) + f_cnt;
            if (f_cnt != '0) begin
                o_run.cp  = f_cp;
                o_run.inv = f_inv;
            end
            o_state.pcount = f_hold ? 2'd1 : 2'd0;
            if (f_hold) o_state.lead = b;
        end

        if (last) o_state.pcount = 2'd0;
    end

endmodule

/* hw/rtl/u8sd_emit.sv */
// Result register that plays out the results of one byte, one beat a cycle while i_stall is low.
module u8sd_emit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  u8sd_pkg::t_run      i_run,
    input  logic                i_stall,
    output logic                o_free,
    output logic                o_valid,
    output u8sd_pkg::t_out_beat o_beat
);

    logic [u8sd_pkg::CountW-1:0] r_cnt;
    logic [u8sd_pkg::CountW-1:0] n_cnt;
    u8sd_pkg::t_run              r_run;

    assign o_valid = (r_cnt != '0);
    assign o_free  = (r_cnt == '0) ||
                     (r_cnt == u8sd_pkg::CountW'(1) && !i_stall);

    always_comb begin
        n_cnt = r_cnt;
        if (i_load) begin
            n_cnt = i_run.cnt;
        end else if (r_cnt != '0 && !i_stall) begin
            n_cnt = r_cnt - u8sd_pkg::CountW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        if (i_load) begin
            r_run <= i_run;
        end
    end

    // Only the final beat of a run carries the decoded value and the flags.
    always_comb begin
        if (r_cnt == u8sd_pkg::CountW'(1)) begin
            o_beat.codepoint   = r_run.cp;
            o_beat.seq_length  = r_run.len;
            o_beat.invalid     = r_run.inv;
            o_beat.run_last    = 1'b1;
            o_beat.string_last = r_run.str_last;
        end else begin
            o_beat.codepoint   = '0;
            o_beat.seq_length  = u8sd_pkg::LenW'(1);
            o_beat.invalid     = 1'b1;
            o_beat.run_last    = 1'b0;
            o_beat.string_last = 1'b0;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= u8sd_pkg::CountW'(u8sd_pkg::MaxRes))
        else $error("run count out of range");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt > u8sd_pkg::CountW'(1) && !i_stall) |=>
        r_cnt == $past(r_cnt) - u8sd_pkg::CountW'(1))
        else $error("run did not advance by one beat");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_beat)))
        else $error("stalled result beat changed");

endmodule

/* hw/rtl/utf8_stream_decoder.sv */
// Top level of the UTF-8 stream decoder: input register, held state, result register.
//
//  channel  direction  valid    stall    payload
//  input    in         i_valid  o_stall  i_beat (byte_in, last_byte)
//  output   out        o_valid  i_stall  o_beat (codepoint, seq_length, invalid,
//                                                 run_last, string_last)
//
// A byte is taken every cycle while o_stall is low; a byte that causes n > 1 results holds
// the input while the result register plays them out.
// An accepted byte goes through the input register and then the result register.
// Reset is synchronous and clears the held sequence and both valid flags.
// A stalled output keeps its beat; the input register still takes one byte.
module utf8_stream_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  u8sd_pkg::t_in_beat  i_beat,
    output logic                o_valid,
    input  logic                i_stall,
    output u8sd_pkg::t_out_beat o_beat
);

    logic                 r_in_valid;
    u8sd_pkg::t_in_beat   r_in;
    u8sd_pkg::t_dec_state r_state;
    u8sd_pkg::t_dec_state n_state;
    u8sd_pkg::t_run       dec_run;
    logic                 run_free;
    logic                 load;
    logic                 accept;

    assign load    = r_in_valid && run_free;
    assign o_stall = r_in_valid && !run_free;
    assign accept  = i_valid && !o_stall;

    u8sd_decode u_decode (
        .i_state (r_state),
        .i_beat  (r_in),
        .o_state (n_state),
        .o_run   (dec_run)
    );

    u8sd_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_run   (dec_run),
        .i_stall (i_stall),
        .o_free  (run_free),
        .o_valid (o_valid),
        .o_beat  (o_beat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_state.lead   <= '0;
            r_state.pcount <= '0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (load) begin
                r_in_valid <= 1'b0;
            end
            if (load) begin
                r_state.lead   <= n_state.lead;
                r_state.pcount <= n_state.pcount;
            end
        end
        if (accept) begin
            r_in <= i_beat;
        end
        if (load) begin
            r_state.cont0 <= n_state.cont0;
            r_state.cont1 <= n_state.cont1;
        end
    end

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && r_in.last_byte) |=> r_state.pcount == 2'd0)
        else $error("sequence still held after end of string");

    a_invalid_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_beat.invalid) |->
        (o_beat.codepoint == '0 && o_beat.seq_length == u8sd_pkg::LenW'(1)))
        else $error("invalid beat carries a value");

    a_str_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_beat.string_last) |-> o_beat.run_last)
        else $error("string end flagged before the end of its run");

endmodule

/* tb/utf8_stream_decoder_checker.sv */
// Checker that predicts the UTF-8 decoder's result beats and compares them on the output channel.
module utf8_stream_decoder_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  u8sd_pkg::t_in_beat  i_in_beat,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  u8sd_pkg::t_out_beat i_out_beat,
    output int                  o_mismatches,
    output int                  o_outstanding
);

    // Held sequence of the predictor.
    logic [7:0] held_lead;
    logic [5:0] held_cont [2];
    logic [1:0] held_count;

    u8sd_pkg::t_out_beat expected_beats [$];
    u8sd_pkg::t_out_beat run_beats [4];
    int                  run_len;
    int                  mismatches = 0;

    function automatic u8sd_pkg::t_kind classify(input logic [7:0] b);
        casez (b)
            8'b0???????: return u8sd_pkg::K_ASCII;
            8'b10??????: return u8sd_pkg::K_CONT;
            8'b110?????: return u8sd_pkg::K_LEAD2;
            8'b1110????: return u8sd_pkg::K_LEAD3;
            8'b11110???: return u8sd_pkg::K_LEAD4;
            default:     return u8sd_pkg::K_BAD;
        endcase
    endfunction

    task automatic add_result(input logic [20:0] cp, input logic [2:0] len, input logic inv);
        run_beats[run_len] = '{codepoint: cp, seq_length: len, invalid: inv,
                               run_last: 1'b0, string_last: 1'b0};
        run_len++;
    endtask

    // One invalid beat for the lead and for every held continuation.
    task automatic flush_held();
        for (int i = 0; i < int'(held_count); i++) begin
            add_result(21'd0, 3'd1, 1'b1);
        end
        held_count = 2'd0;
    endtask

    task automatic start_fresh(input logic [7:0] b, input logic last);
        u8sd_pkg::t_kind k;
        k = classify(b);
        if (k == u8sd_pkg::K_ASCII) begin
            add_result({14'd0, b[6:0]}, 3'd1, 1'b0);
        end else if (k == u8sd_pkg::K_CONT || k == u8sd_pkg::K_BAD || last) begin
            add_result(21'd0, 3'd1, 1'b1);
        end else begin
            held_lead  = b;
            held_count = 2'd1;
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic last);
        int unsigned need;
        int unsigned have;
        logic [20:0] cp;
        run_len = 0;
        if (held_count != 2'd0) begin
            case (classify(held_lead))
                u8sd_pkg::K_LEAD3: need = 2;
                u8sd_pkg::K_LEAD4: need = 3;
                default:           need = 1;
            endcase
            have = int'(held_count) - 1;
            if (classify(b) == u8sd_pkg::K_CONT) begin
                if (have + 1 >= need) begin
                    case (need)
                        1:       cp = {10'd0, held_lead[4:0], b[5:0]};
                        2:       cp = {5'd0, held_lead[3:0], held_cont[0], b[5:0]};
                        default: cp = {held_lead[2:0], held_cont[0], held_cont[1], b[5:0]};
                    endcase
                    add_result(cp, 3'(need + 1), 1'b0);
                    held_count = 2'd0;
                end else begin
                    held_cont[have[0]] = b[5:0];
                    held_count = held_count + 2'd1;
                    if (last) flush_held();
                end
            end else begin
                flush_held();
                start_fresh(b, last);
            end
        end else begin
            start_fresh(b, last);
        end
        if (last) held_count = 2'd0;
        if (run_len > 0) begin
            run_beats[run_len-1].run_last    = 1'b1;
            run_beats[run_len-1].string_last = last;
            for (int i = 0; i < run_len; i++) expected_beats.push_back(run_beats[i]);
        end
    endtask

    task automatic log_mismatch(input bit have_want, input u8sd_pkg::t_out_beat want,
                                input u8sd_pkg::t_out_beat got);
        if (mismatches < 10) begin
            if (have_want) begin
                $display("[%0t] result mismatch: expected cp=%h len=%0d inv=%b run=%b str=%b",
                         $time, want.codepoint, want.seq_length, want.invalid,
                         want.run_last, want.string_last);
            end else begin
                $display("[%0t] result beat with nothing expected", $time);
            end
            $display("    got cp=%h len=%0d inv=%b run=%b str=%b", got.codepoint,
                     got.seq_length, got.invalid, got.run_last, got.string_last);
        end
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        u8sd_pkg::t_out_beat want;
        if (!i_rst_n) begin
            held_lead  = 8'h00;
            held_count = 2'd0;
            expected_beats.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_beats.size() == 0) begin
                    log_mismatch(1'b0, i_out_beat, i_out_beat);
                end else begin
                    want = expected_beats.pop_front();
                    if (i_out_beat.codepoint !== want.codepoint
                        || i_out_beat.seq_length !== want.seq_length
                        || i_out_beat.invalid !== want.invalid
                        || i_out_beat.run_last !== want.run_last
                        || i_out_beat.string_last !== want.string_last) begin
                        log_mismatch(1'b1, want, i_out_beat);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                decode_byte(i_in_beat.byte_in, i_in_beat.last_byte);
            end
        end
        o_outstanding <= expected_beats.size();
        o_mismatches  <= mismatches;
    end

endmodule

/* tb/utf8_stream_decoder_tb.sv */
// Top of the UTF-8 stream decoder testbench: clock, reset, byte stimulus and verdict.
module utf8_stream_decoder_tb;

    localparam int LONG_HOLD   = 150;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_BYTES = 500;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    u8sd_pkg::t_in_beat  i_beat;
    logic                o_valid;
    logic                i_stall;
    u8sd_pkg::t_out_beat o_beat;

    int mismatches;
    int outstanding;
    int hold_req = 0;
    int hold_ack = 0;
    int cycle_count = 0;
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;

    logic [7:0] utf8_bytes [$];

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    utf8_stream_decoder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_beat  (i_beat),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_beat  (o_beat)
    );

    utf8_stream_decoder_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_in_beat     (i_beat),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_out_beat    (o_beat),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    function automatic logic [7:0] cont_byte();
        return {2'b10, 6'($urandom())};
    endfunction

    function automatic logic [7:0] lead_byte_of(input int unsigned len);
        case (len)
            2:       return {3'b110, 5'($urandom())};
            3:       return {4'b1110, 4'($urandom())};
            default: return {5'b11110, 3'($urandom())};
        endcase
    endfunction

    // Mostly well-formed symbols; the rest are cut sequences, strays and junk.
    task automatic add_symbol();
        int unsigned pick;
        int unsigned len;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            utf8_bytes.push_back({1'b0, 7'($urandom())});
        end else if (pick < 75) begin
            len = (pick < 45) ? 2 : (pick < 60) ? 3 : 4;
            utf8_bytes.push_back(lead_byte_of(len));
            repeat (len - 1) utf8_bytes.push_back(cont_byte());
        end else if (pick < 83) begin
            len = $urandom_range(2, 4);
            utf8_bytes.push_back(lead_byte_of(len));
            repeat ($urandom_range(0, len - 2)) utf8_bytes.push_back(cont_byte());
        end else if (pick < 90) begin
            utf8_bytes.push_back(cont_byte());
        end else if (pick < 95) begin
            utf8_bytes.push_back({5'b11111, 3'($urandom())});
        end else begin
            utf8_bytes.push_back(8'($urandom()));
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        if ($urandom_range(0, 49) == 0) tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_beat  <= '{byte_in: b, last_byte: last};
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Stop sending until every predicted beat has been seen.
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        // Bit 8 carries the last-byte flag.
        logic [8:0] directed_q [$];
        int random_items;
        int next_hold;
        bit paused;
        logic last;
        directed_q = '{
            9'h000, 9'h07F,                   // ASCII extremes
            9'h0C0, 9'h080, 9'h0DF, 9'h0BF,   // two-byte extremes
            9'h0E0, 9'h080, 9'h080,           // three-byte
            9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,   // four-byte
            9'h080, 9'h0FF, 9'h0F8,           // stray continuation and bad leads
            9'h1C5,                           // lead on the last byte
            9'h0E0, 9'h180,                   // string ends early
            9'h0F0, 9'h080, 9'h080, 9'h141    // broken sequence, then ASCII
        };
        random_items = 0;
        next_hold    = 120;
        paused       = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_beat  = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_q[i]) send_byte(directed_q[i][7:0], directed_q[i][8]);
        drain_results();

        while (random_items < RANDOM_BYTES) begin
            if (random_items >= next_hold) begin
                hold_req++;
                tx_calm = 1'b1;
                next_hold += 200;
            end
            if (!paused && random_items >= 250) begin
                drain_results();
                paused = 1'b1;
            end
            utf8_bytes.delete();
            repeat ($urandom_range(1, 6)) add_symbol();
            foreach (utf8_bytes[i]) begin
                last = (i == utf8_bytes.size() - 1) || ($urandom_range(0, 39) == 0);
                send_byte(utf8_bytes[i], last);
                random_items++;
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin : receiver
        int unsigned gap;
        i_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
            // A long hold-off lets the decoder fill up and push back on its input.
            if (hold_ack != hold_req) begin
                hold_ack++;
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            gap = rx_calm ? 0 : $urandom_range(0, 17);
            if (gap != 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/u8sd_pkg.sv
hw/rtl/u8sd_decode.sv
hw/rtl/u8sd_emit.sv
hw/rtl/utf8_stream_decoder.sv
tb/utf8_stream_decoder_checker.sv
tb/utf8_stream_decoder_tb.sv
